FILE: hdl/abnf_pkg.sv
`timescale 1ns / 1ps

package abnf_pkg;

  localparam int unsigned LengthBitsDefault = 16;
  localparam int unsigned OutLenBits = 16;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrBits = 2;

  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChStar = 8'h2A;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot = 8'h2E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChLess = 8'h3C;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChGreater = 8'h3E;
  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D;
  localparam logic [7:0] ChLowB = 8'h62;
  localparam logic [7:0] ChLowD = 8'h64;
  localparam logic [7:0] ChLowX = 8'h78;
  localparam logic [7:0] ChUpB = 8'h42;
  localparam logic [7:0] ChUpD = 8'h44;
  localparam logic [7:0] ChUpX = 8'h58;

  typedef enum logic [4:0] {
    TK_NEWLINE = 5'd0,
    TK_COMMENT = 5'd1,
    TK_SLASH   = 5'd2,
    TK_STAR    = 5'd3,
    TK_LPAREN  = 5'd4,
    TK_RPAREN  = 5'd5,
    TK_LBRACK  = 5'd6,
    TK_RBRACK  = 5'd7,
    TK_MINUS   = 5'd8,
    TK_DOT     = 5'd9,
    TK_RULEDEF = 5'd10,
    TK_AMEND   = 5'd11,
    TK_HEXMODE = 5'd12,
    TK_BINMODE = 5'd13,
    TK_DECMODE = 5'd14,
    TK_QUOTED  = 5'd15,
    TK_PROSE   = 5'd16,
    TK_NUMBER  = 5'd17,
    TK_HEXNUM  = 5'd18,
    TK_NAME    = 5'd19,
    TK_ERROR   = 5'd20,
    TK_END     = 5'd21
  } token_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LITERAL  = 3'd1,
    ERR_QUOTES   = 3'd2,
    ERR_BRACKETS = 3'd3,
    ERR_CHAR     = 3'd4
  } error_kind_e;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_CR      = 10'b00_0000_0010,
    ST_COMMENT = 10'b00_0000_0100,
    ST_EQ      = 10'b00_0000_1000,
    ST_PCT     = 10'b00_0001_0000,
    ST_QUOTE   = 10'b00_0010_0000,
    ST_PROSE   = 10'b00_0100_0000,
    ST_DEC     = 10'b00_1000_0000,
    ST_HEX     = 10'b01_0000_0000,
    ST_NAME    = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    token_kind_e            kind;
    error_kind_e            err;
    logic [OutLenBits-1:0]  len;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic     emit;
    result_t  res;
    state_e   state;
    logic     one;
  } start_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_xdigit(logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic result_t make_result(token_kind_e kind, error_kind_e err,
                                          logic [OutLenBits-1:0] len);
    result_t r;
    r.kind = kind;
    r.err  = err;
    r.len  = len;
    r.last = 1'b0;
    return r;
  endfunction

  // Decides what a byte does when no token is in progress.
  function automatic start_t start_token(logic [7:0] c, logic hex_sel);
    start_t s;
    s.emit  = 1'b0;
    s.res   = make_result(TK_END, ERR_NONE, '0);
    s.state = ST_IDLE;
    s.one   = 1'b1;
    priority if (c == ChNul) begin
      s.emit = 1'b1;
      s.one  = 1'b0;
    end else if (c == ChLf) begin
      s.emit = 1'b1;
      s.one  = 1'b0;
      s.res  = make_result(TK_NEWLINE, ERR_NONE, OutLenBits'(1));
    end else if (c == ChSlash || c == ChStar || c == ChLParen || c == ChRParen ||
                 c == ChLBrack || c == ChRBrack || c == ChMinus || c == ChDot) begin
      s.emit = 1'b1;
      s.one  = 1'b0;
      unique case (c)
        ChSlash:  s.res = make_result(TK_SLASH, ERR_NONE, OutLenBits'(1));
        ChStar:   s.res = make_result(TK_STAR, ERR_NONE, OutLenBits'(1));
        ChLParen: s.res = make_result(TK_LPAREN, ERR_NONE, OutLenBits'(1));
        ChRParen: s.res = make_result(TK_RPAREN, ERR_NONE, OutLenBits'(1));
        ChLBrack: s.res = make_result(TK_LBRACK, ERR_NONE, OutLenBits'(1));
        ChRBrack: s.res = make_result(TK_RBRACK, ERR_NONE, OutLenBits'(1));
        ChMinus:  s.res = make_result(TK_MINUS, ERR_NONE, OutLenBits'(1));
        default:  s.res = make_result(TK_DOT, ERR_NONE, OutLenBits'(1));
      endcase
    end else if (c == ChCr) begin
      s.state = ST_CR;
    end else if (c == ChSemi) begin
      s.state = ST_COMMENT;
    end else if (c == ChEqual) begin
      s.state = ST_EQ;
    end else if (c == ChPercent) begin
      s.state = ST_PCT;
    end else if (c == ChQuote) begin
      s.state = ST_QUOTE;
    end else if (c == ChLess) begin
      s.state = ST_PROSE;
    end else if (is_digit(c)) begin
      s.state = hex_sel ? ST_HEX : ST_DEC;
    end else if (hex_sel && is_xdigit(c)) begin
      s.state = ST_HEX;
    end else if (is_alpha(c)) begin
      s.state = ST_NAME;
    end else begin
      s.emit = 1'b1;
      s.one  = 1'b0;
      s.res  = make_result(TK_ERROR, ERR_CHAR, OutLenBits'(1));
    end
    return s;
  endfunction

endpackage

FILE: hdl/abnf_if.sv
`timescale 1ns / 1ps

interface abnf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       hex_digits_mode;

  modport source (output valid, output text_byte, output hex_digits_mode, input ready);
  modport sink (input valid, input text_byte, input hex_digits_mode, output ready);
endinterface

interface abnf_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [2:0]  error_kind;
  logic [15:0] token_length;
  logic        last_result;

  modport source (output valid, output token_kind, output error_kind, output token_length,
                  output last_result, input ready);
  modport sink (input valid, input token_kind, input error_kind, input token_length,
                input last_result, output ready);
endinterface

FILE: hdl/abnf_grammar_tokenizer.sv
`timescale 1ns / 1ps

// Channel  Direction  Payload
// in_i     sink       text_byte[7:0], hex_digits_mode
// out_o    source     token_kind[4:0], error_kind[2:0], token_length[15:0], last_result
//
// One text byte is taken per cycle while in_i.ready is high. Its results, none, one or two, are written into a
// four-entry result queue at that edge and leave one per transfer from the next cycle.
// A byte is taken while the queue holds at most two results, so one byte per cycle is
// kept while the output side takes a result every cycle and bytes give at most one
// result each; a byte that gives two results needs two output transfers.
// Reset clears the tokenizer to idle and empties the queue.
// A stalled output fills the queue and then stops input; no result is lost.

module abnf_grammar_tokenizer #(
  parameter int unsigned LengthBits = abnf_pkg::LengthBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  abnf_in_if.sink    in_i,
  abnf_out_if.source out_o
);

  localparam int unsigned OutLen = abnf_pkg::OutLenBits;
  localparam int unsigned PtrW = abnf_pkg::QueuePtrBits;
  localparam int unsigned CntW = PtrW + 1;
  localparam logic [LengthBits-1:0] LenMax = '1;

  abnf_pkg::state_e state_q, state_d;
  logic [LengthBits-1:0] len_q, len_d, len_inc;
  logic [OutLen-1:0] len_out, len_inc_out;

  abnf_pkg::result_t p_res, q_res, r0, r1;
  abnf_pkg::start_t start;
  logic p_v, q_v, restart, extra_end;
  logic [7:0] c;

  abnf_pkg::result_t queue_q [abnf_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic in_fire, out_fire;
  logic [1:0] push_n;

  function automatic logic [OutLen-1:0] clip_len(logic [LengthBits-1:0] v);
    if ((LengthBits > OutLen) && ((v >> OutLen) != '0)) begin
      return '1;
    end
    return OutLen'(v);
  endfunction

  assign c = in_i.text_byte;
  assign len_inc = (len_q == LenMax) ? len_q : len_q + LengthBits'(1);
  assign len_out = clip_len(len_q);
  assign len_inc_out = clip_len(len_inc);
  assign start = abnf_pkg::start_token(c, in_i.hex_digits_mode);

  always_comb begin
    p_v = 1'b0;
    q_v = 1'b0;
    p_res = abnf_pkg::make_result(abnf_pkg::TK_END, abnf_pkg::ERR_NONE, '0);
    q_res = abnf_pkg::make_result(abnf_pkg::TK_END, abnf_pkg::ERR_NONE, '0);
    restart = 1'b0;
    extra_end = 1'b0;
    state_d = state_q;
    len_d = len_q;
    unique case (state_q)
      abnf_pkg::ST_CR: begin
        p_v = 1'b1;
        if (c == abnf_pkg::ChLf) begin
          p_res = abnf_pkg::make_result(abnf_pkg::TK_NEWLINE, abnf_pkg::ERR_NONE, len_inc_out);
          state_d = abnf_pkg::ST_IDLE;
          len_d = '0;
        end else begin
          p_res = abnf_pkg::make_result(abnf_pkg::TK_NEWLINE, abnf_pkg::ERR_NONE, len_out);
          restart = 1'b1;
        end
      end
      abnf_pkg::ST_COMMENT: begin
        if (c == abnf_pkg::ChNul || c == abnf_pkg::ChLf || c == abnf_pkg::ChCr) begin
          p_v = 1'b1;
          p_res = abnf_pkg::make_result(abnf_pkg::TK_COMMENT, abnf_pkg::ERR_NONE, len_out);
          restart = 1'b1;
        end else begin
          len_d = len_inc;
        end
      end
      abnf_pkg::ST_EQ: begin
        p_v = 1'b1;
        if (c == abnf_pkg::ChSlash) begin
          p_res = abnf_pkg::make_result(abnf_pkg::TK_AMEND, abnf_pkg::ERR_NONE, len_inc_out);
          state_d = abnf_pkg::ST_IDLE;
          len_d = '0;
        end else begin
          p_res = abnf_pkg::make_result(abnf_pkg::TK_RULEDEF, abnf_pkg::ERR_NONE, len_out);
          restart = 1'b1;
        end
      end
      abnf_pkg::ST_PCT: begin
        p_v = 1'b1;
        state_d = abnf_pkg::ST_IDLE;
        len_d = '0;
        priority if (c == abnf_pkg::ChLowX || c == abnf_pkg::ChUpX) begin
          p_res = abnf_pkg::make_result(abnf_pkg::TK_HEXMODE, abnf_pkg::ERR_NONE, len_inc_out);
        end else if (c == abnf_pkg::ChLowB || c == abnf_pkg::ChUpB) begin
          p_res = abnf_pkg::make_result(abnf_pkg::TK_BINMODE, abnf_pkg::ERR_NONE, len_inc_out);
        end else if (c == abnf_pkg::ChLowD || c == abnf_pkg::ChUpD) begin
          p_res = abnf_pkg::make_result(abnf_pkg::TK_DECMODE, abnf_pkg::ERR_NONE, len_inc_out);
        end else if (c == abnf_pkg::ChNul) begin
          p_res = abnf_pkg::make_result(abnf_pkg::TK_ERROR, abnf_pkg::ERR_LITERAL, len_out);
          extra_end = 1'b1;
        end else begin
          p_res = abnf_pkg::make_result(abnf_pkg::TK_ERROR, abnf_pkg::ERR_LITERAL, len_inc_out);
        end
      end
      abnf_pkg::ST_QUOTE: begin
        if (c == abnf_pkg::ChQuote) begin
          p_v = 1'b1;
          p_res = abnf_pkg::make_result(abnf_pkg::TK_QUOTED, abnf_pkg::ERR_NONE, len_inc_out);
          state_d = abnf_pkg::ST_IDLE;
          len_d = '0;
        end else if (c == abnf_pkg::ChNul) begin
          p_v = 1'b1;
          p_res = abnf_pkg::make_result(abnf_pkg::TK_ERROR, abnf_pkg::ERR_QUOTES, len_out);
          restart = 1'b1;
        end else begin
          len_d = len_inc;
        end
      end
      abnf_pkg::ST_PROSE: begin
        if (c == abnf_pkg::ChGreater) begin
          p_v = 1'b1;
          p_res = abnf_pkg::make_result(abnf_pkg::TK_PROSE, abnf_pkg::ERR_NONE, len_inc_out);
          state_d = abnf_pkg::ST_IDLE;
          len_d = '0;
        end else if (c == abnf_pkg::ChNul) begin
          p_v = 1'b1;
          p_res = abnf_pkg::make_result(abnf_pkg::TK_ERROR, abnf_pkg::ERR_BRACKETS, len_out);
          restart = 1'b1;
        end else begin
          len_d = len_inc;
        end
      end
      abnf_pkg::ST_DEC: begin
        if (abnf_pkg::is_digit(c)) begin
          len_d = len_inc;
        end else begin
          p_v = 1'b1;
          p_res = abnf_pkg::make_result(abnf_pkg::TK_NUMBER, abnf_pkg::ERR_NONE, len_out);
          restart = 1'b1;
        end
      end
      abnf_pkg::ST_HEX: begin
        if (abnf_pkg::is_xdigit(c)) begin
          len_d = len_inc;
        end else begin
          p_v = 1'b1;
          p_res = abnf_pkg::make_result(abnf_pkg::TK_HEXNUM, abnf_pkg::ERR_NONE, len_out);
          restart = 1'b1;
        end
      end
      abnf_pkg::ST_NAME: begin
        if (abnf_pkg::is_alpha(c) || abnf_pkg::is_digit(c) || c == abnf_pkg::ChMinus) begin
          len_d = len_inc;
        end else begin
          p_v = 1'b1;
          p_res = abnf_pkg::make_result(abnf_pkg::TK_NAME, abnf_pkg::ERR_NONE, len_out);
          restart = 1'b1;
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    if (restart) begin
      state_d = start.state;
      len_d = LengthBits'(start.one);
      q_v = start.emit;
      q_res = start.res;
    end
    if (extra_end) begin
      q_v = 1'b1;
    end

    r0 = p_v ? p_res : q_res;
    r1 = q_res;
    r1.last = 1'b1;
    r0.last = !(p_v && q_v);
    push_n = {1'b0, p_v} + {1'b0, q_v};
  end

  assign in_i.ready = (count_q <= CntW'(abnf_pkg::QueueDepth - 2));
  assign in_fire = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  always_comb begin
    count_d = count_q;
    if (in_fire) begin
      count_d = count_d + CntW'(push_n);
    end
    if (out_fire) begin
      count_d = count_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= abnf_pkg::ST_IDLE;
      len_q <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        state_q <= state_d;
        len_q <= len_d;
        wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= r0;
    end
    if (in_fire && push_n == 2'd2) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= r1;
    end
  end

  assign out_o.valid = (count_q != '0);
  assign out_o.token_kind = queue_q[rd_ptr_q].kind;
  assign out_o.error_kind = queue_q[rd_ptr_q].err;
  assign out_o.token_length = queue_q[rd_ptr_q].len;
  assign out_o.last_result = queue_q[rd_ptr_q].last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(abnf_pkg::QueueDepth))
    else $error("result queue overflow");

  a_nul_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && c == abnf_pkg::ChNul) |=> (state_q == abnf_pkg::ST_IDLE && len_q == '0))
    else $error("tokenizer not idle after end of text");

  a_byte_gives_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && push_n != 2'd0) |-> (push_n == 2'd1 ? r0.last : (r1.last && !r0.last)))
    else $error("last result flag misplaced");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_fire && out_fire) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("result queue count mismatch");
`endif

endmodule
